/* hw/rtl/sbf_pkg.sv */
// Package for the spring/bungee force pipeline: fixed-point widths, register
// indexes and the input and result item types.
// No dependencies; used by every file under hw/rtl.
package sbf_pkg;

    localparam int FRAC_BITS = 16;
    localparam int XW    = 32;                 // position and force width
    localparam int DW    = XW + 1;             // separation magnitude width
    localparam int SUMW  = 2 * DW;             // squared length width
    localparam int LW    = DW + 2;             // length width
    localparam int RW    = 2 * LW;             // square root remainder width
    localparam int QW    = FRAC_BITS + 1;      // unit vector component width
    localparam int NW    = DW + FRAC_BITS;     // divider numerator width
    localparam int DRW   = LW + QW;            // divider remainder width
    localparam int KW    = 32;                 // spring constant width
    localparam int RLW   = 31;                 // rest length width
    localparam int SHW   = LW - KW;            // upper slice of the stretch
    localparam int PW    = KW + LW;            // stiffness product width
    localparam int MSW   = PW - FRAC_BITS;     // shifted stiffness product
    localparam int MW    = DW + 1 + FRAC_BITS; // clamped magnitude width
    localparam int FPW   = MW + QW;            // force product width
    localparam int FSW   = FPW - FRAC_BITS;    // shifted force product

    localparam logic [MW-1:0]  MAG_CLAMP = MW'(1) << (MW - 1);
    localparam logic [XW-1:0]  POS_LIMIT = {1'b0, {(XW-1){1'b1}}};
    localparam logic [XW-1:0]  NEG_LIMIT = {1'b1, {(XW-1){1'b0}}};

    localparam logic [0:0] REG_SPRING_CONSTANT = 1'b0;
    localparam logic [0:0] REG_REST_LENGTH     = 1'b1;

    localparam logic [KW-1:0]  SPRING_CONSTANT_RESET = KW'(65536);
    localparam logic [RLW-1:0] REST_LENGTH_RESET     = RLW'(65536);

    typedef struct packed {
        logic          func;
        logic [XW-1:0] pos_x;
        logic [XW-1:0] pos_y;
        logic [XW-1:0] pos_z;
        logic [XW-1:0] other_x;
        logic [XW-1:0] other_y;
        logic [XW-1:0] other_z;
    } sbf_in_t;

    typedef struct packed {
        logic [XW-1:0] force_x;
        logic [XW-1:0] force_y;
        logic [XW-1:0] force_z;
        logic          applied;
        logic          saturated;
    } sbf_out_t;

endpackage

/* hw/rtl/sbf_isqrt.sv */
// Pipelined integer square root, one root bit per stage, LW stages.
// Depends on sbf_pkg for widths.
module sbf_isqrt
(
    input  logic                      clk,
    input  logic                      en,
    input  logic [sbf_pkg::SUMW-1:0]  rad,
    output logic [sbf_pkg::LW-1:0]    root
);

    logic [sbf_pkg::RW-1:0] rem_reg  [sbf_pkg::LW];
    logic [sbf_pkg::LW-1:0] root_reg [sbf_pkg::LW];

    for (genvar i = 0; i < sbf_pkg::LW; i++)
    begin : g_stage
        localparam int B = sbf_pkg::LW - 1 - i;
        logic [sbf_pkg::RW-1:0] rem_in;
        logic [sbf_pkg::RW-1:0] trial;
        logic [sbf_pkg::LW-1:0] r_in;

        if (i == 0)
        begin : g_first
            assign rem_in = sbf_pkg::RW'(rad);
            assign r_in   = '0;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[i-1];
            assign r_in   = root_reg[i-1];
        end

        // (r + 2^B)^2 - r^2
        assign trial = (sbf_pkg::RW'(r_in) << (B + 1)) + (sbf_pkg::RW'(1) << (2 * B));

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (rem_in >= trial)
                begin
                    rem_reg[i]  <= rem_in - trial;
                    root_reg[i] <= r_in | (sbf_pkg::LW'(1) << B);
                end
                else
                begin
                    rem_reg[i]  <= rem_in;
                    root_reg[i] <= r_in;
                end
            end
        end
    end

    assign root = root_reg[sbf_pkg::LW-1];

endmodule

/* hw/rtl/sbf_div.sv */
// Pipelined restoring divider, one quotient bit per stage, QW stages.
// Depends on sbf_pkg for widths; the quotient must fit in QW bits.
module sbf_div
(
    input  logic                    clk,
    input  logic                    en,
    input  logic [sbf_pkg::NW-1:0]  num,
    input  logic [sbf_pkg::LW-1:0]  den,
    output logic [sbf_pkg::QW-1:0]  quo
);

    logic [sbf_pkg::DRW-1:0] rem_reg [sbf_pkg::QW];
    logic [sbf_pkg::LW-1:0]  den_reg [sbf_pkg::QW];
    logic [sbf_pkg::QW-1:0]  quo_reg [sbf_pkg::QW];

    for (genvar i = 0; i < sbf_pkg::QW; i++)
    begin : g_stage
        localparam int Q = sbf_pkg::QW - 1 - i;
        logic [sbf_pkg::DRW-1:0] rem_in;
        logic [sbf_pkg::DRW-1:0] trial;
        logic [sbf_pkg::LW-1:0]  den_in;
        logic [sbf_pkg::QW-1:0]  q_in;

        if (i == 0)
        begin : g_first
            assign rem_in = sbf_pkg::DRW'(num);
            assign den_in = den;
            assign q_in   = '0;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[i-1];
            assign den_in = den_reg[i-1];
            assign q_in   = quo_reg[i-1];
        end

        assign trial = sbf_pkg::DRW'(den_in) << Q;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                den_reg[i] <= den_in;
                if (rem_in >= trial)
                begin
                    rem_reg[i] <= rem_in - trial;
                    quo_reg[i] <= q_in | (sbf_pkg::QW'(1) << Q);
                end
                else
                begin
                    rem_reg[i] <= rem_in;
                    quo_reg[i] <= q_in;
                end
            end
        end
    end

    assign quo = quo_reg[sbf_pkg::QW-1];

endmodule

/* hw/rtl/spring_bungee_force.sv */
// Spring / bungee force: takes one item per cycle while the output is not
// stalled and returns one result per item (difference, squaring and sum registers,
// 35 stages of square root, 1 stretch stage, 17 divider stages, then the force
// product and output registers). The whole pipeline holds while a result waits
// at the output.
// Depends on sbf_pkg, sbf_isqrt and sbf_div.
module spring_bungee_force
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  sbf_pkg::sbf_in_t           in_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output sbf_pkg::sbf_out_t          out_data,
    input  logic                       cfg_we,
    input  logic [0:0]                 cfg_index,
    input  logic [sbf_pkg::KW-1:0]     cfg_data
);

    typedef struct packed {
        logic                              vld;
        logic                              func;
        logic [2:0][sbf_pkg::DW-1:0]       dmag;
        logic [2:0]                        dneg;
    } diff_t;

    typedef struct packed {
        logic                              vld;
        logic                              func;
        logic [2:0][sbf_pkg::DW-1:0]       dmag;
        logic [2:0]                        dneg;
        logic [2:0][sbf_pkg::SUMW-1:0]     sq;
    } sq_t;

    typedef struct packed {
        logic                              vld;
        logic                              func;
        logic [2:0][sbf_pkg::DW-1:0]       dmag;
        logic [2:0]                        dneg;
        logic [sbf_pkg::SUMW-1:0]          sum;
    } sum_t;

    typedef struct packed {
        logic                              vld;
        logic                              kill;
        logic                              sneg;
        logic [sbf_pkg::LW-1:0]            len;
        logic [sbf_pkg::LW-1:0]            smag;
        logic [2:0][sbf_pkg::DW-1:0]       dmag;
        logic [2:0]                        dneg;
    } stretch_t;

    typedef struct packed {
        logic                              vld;
        logic                              kill;
        logic                              sneg;
        logic [2:0]                        dneg;
    } side_t;

    typedef struct packed {
        logic                              vld;
        logic                              kill;
        logic                              sneg;
        logic [2:0]                        dneg;
        logic [2:0][sbf_pkg::FPW-1:0]      prod;
    } prod_t;

    logic                        en;
    logic [sbf_pkg::KW-1:0]      spring_constant_reg;
    logic [sbf_pkg::RLW-1:0]     rest_length_reg;

    diff_t                       a_reg, a_next;
    sq_t                         b_reg;
    sum_t                        c_reg;
    diff_t                       sd_q [sbf_pkg::LW];
    logic [sbf_pkg::LW-1:0]      len;
    stretch_t                    d_reg, d_next;
    logic [2*sbf_pkg::KW-1:0]    plo_reg;
    logic [sbf_pkg::KW+sbf_pkg::SHW-1:0] phi_reg;
    logic [sbf_pkg::PW-1:0]      ptot;
    logic [sbf_pkg::MSW-1:0]     pshift;
    logic [sbf_pkg::MW-1:0]      mmag;
    side_t                       md_q [sbf_pkg::QW];
    logic [sbf_pkg::MW-1:0]      mm_q [sbf_pkg::QW-1];
    logic [2:0][sbf_pkg::QW-1:0] quo;
    prod_t                       g_reg;
    sbf_pkg::sbf_out_t           out_reg, out_next;
    logic                        out_valid_reg;

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spring_constant_reg <= sbf_pkg::SPRING_CONSTANT_RESET;
            rest_length_reg     <= sbf_pkg::REST_LENGTH_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sbf_pkg::REG_SPRING_CONSTANT: spring_constant_reg <= cfg_data;
                sbf_pkg::REG_REST_LENGTH:     rest_length_reg <= cfg_data[sbf_pkg::RLW-1:0];
                default: ;
            endcase
        end
    end

    // stage A: separation
    always_comb
    begin
        logic [2:0][sbf_pkg::XW-1:0] p;
        logic [2:0][sbf_pkg::XW-1:0] o;
        logic [sbf_pkg::DW-1:0]      diff;
        p = {in_data.pos_z, in_data.pos_y, in_data.pos_x};
        o = {in_data.other_z, in_data.other_y, in_data.other_x};
        a_next      = '0;
        a_next.vld  = in_valid;
        a_next.func = in_data.func;
        for (int i = 0; i < 3; i++)
        begin
            diff = {p[i][sbf_pkg::XW-1], p[i]} - {o[i][sbf_pkg::XW-1], o[i]};
            a_next.dneg[i] = diff[sbf_pkg::DW-1];
            a_next.dmag[i] = diff[sbf_pkg::DW-1] ? (~diff + sbf_pkg::DW'(1)) : diff;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg <= '0;
            b_reg <= '0;
            c_reg <= '0;
        end
        else if (en)
        begin
            a_reg      <= a_next;
            b_reg.vld  <= a_reg.vld;
            b_reg.func <= a_reg.func;
            b_reg.dmag <= a_reg.dmag;
            b_reg.dneg <= a_reg.dneg;
            for (int i = 0; i < 3; i++)
            begin
                b_reg.sq[i] <= sbf_pkg::SUMW'(a_reg.dmag[i]) * sbf_pkg::SUMW'(a_reg.dmag[i]);
            end
            c_reg.vld  <= b_reg.vld;
            c_reg.func <= b_reg.func;
            c_reg.dmag <= b_reg.dmag;
            c_reg.dneg <= b_reg.dneg;
            c_reg.sum  <= b_reg.sq[0] + b_reg.sq[1] + b_reg.sq[2];
        end
    end

    sbf_isqrt u_isqrt
    (
        .clk  (clk),
        .en   (en),
        .rad  (c_reg.sum),
        .root (len)
    );

    // carry the separation alongside the root stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < sbf_pkg::LW; k++)
            begin
                sd_q[k] <= '0;
            end
        end
        else if (en)
        begin
            sd_q[0] <= '{vld: c_reg.vld, func: c_reg.func, dmag: c_reg.dmag, dneg: c_reg.dneg};
            for (int k = 1; k < sbf_pkg::LW; k++)
            begin
                sd_q[k] <= sd_q[k-1];
            end
        end
    end

    // stage D: stretch and the cases that give no force
    always_comb
    begin
        logic [sbf_pkg::LW-1:0] rest;
        rest          = sbf_pkg::LW'(rest_length_reg);
        d_next.vld    = sd_q[sbf_pkg::LW-1].vld;
        d_next.dmag   = sd_q[sbf_pkg::LW-1].dmag;
        d_next.dneg   = sd_q[sbf_pkg::LW-1].dneg;
        d_next.len    = len;
        d_next.kill   = (len == '0) || (sd_q[sbf_pkg::LW-1].func && (len <= rest));
        d_next.sneg   = len < rest;
        d_next.smag   = (len < rest) ? (rest - len) : (len - rest);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_reg <= '0;
        end
        else if (en)
        begin
            d_reg <= d_next;
        end
    end

    for (genvar i = 0; i < 3; i++)
    begin : g_div
        sbf_div u_div
        (
            .clk (clk),
            .en  (en),
            .num ({d_reg.dmag[i], {sbf_pkg::FRAC_BITS{1'b0}}}),
            .den (d_reg.len),
            .quo (quo[i])
        );
    end

    // stiffness times stretch, split into two partial products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            plo_reg <= (2*sbf_pkg::KW)'(spring_constant_reg)
                     * (2*sbf_pkg::KW)'(d_reg.smag[sbf_pkg::KW-1:0]);
            phi_reg <= (sbf_pkg::KW+sbf_pkg::SHW)'(spring_constant_reg)
                     * (sbf_pkg::KW+sbf_pkg::SHW)'(d_reg.smag[sbf_pkg::LW-1:sbf_pkg::KW]);
        end
    end

    assign ptot   = sbf_pkg::PW'(plo_reg) + (sbf_pkg::PW'(phi_reg) << sbf_pkg::KW);
    assign pshift = ptot[sbf_pkg::PW-1:sbf_pkg::FRAC_BITS];
    assign mmag   = (pshift > sbf_pkg::MSW'(sbf_pkg::MAG_CLAMP)) ? sbf_pkg::MAG_CLAMP
                                                                 : pshift[sbf_pkg::MW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < sbf_pkg::QW; k++)
            begin
                md_q[k] <= '0;
            end
        end
        else if (en)
        begin
            md_q[0] <= '{vld: d_reg.vld, kill: d_reg.kill, sneg: d_reg.sneg, dneg: d_reg.dneg};
            for (int k = 1; k < sbf_pkg::QW; k++)
            begin
                md_q[k] <= md_q[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mm_q[0] <= mmag;
            for (int k = 1; k < sbf_pkg::QW - 1; k++)
            begin
                mm_q[k] <= mm_q[k-1];
            end
        end
    end

    // stage G: magnitude times unit vector
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g_reg <= '0;
        end
        else if (en)
        begin
            g_reg.vld  <= md_q[sbf_pkg::QW-1].vld;
            g_reg.kill <= md_q[sbf_pkg::QW-1].kill;
            g_reg.sneg <= md_q[sbf_pkg::QW-1].sneg;
            g_reg.dneg <= md_q[sbf_pkg::QW-1].dneg;
            for (int i = 0; i < 3; i++)
            begin
                g_reg.prod[i] <= sbf_pkg::FPW'(mm_q[sbf_pkg::QW-2]) * sbf_pkg::FPW'(quo[i]);
            end
        end
    end

    // shift, sign and clamp
    always_comb
    begin
        logic [2:0][sbf_pkg::XW-1:0] f;
        logic [sbf_pkg::FSW-1:0]     fs;
        logic                        sat;
        sat = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            fs = g_reg.prod[i][sbf_pkg::FPW-1:sbf_pkg::FRAC_BITS];
            if (fs == '0)
            begin
                f[i] = '0;
            end
            else if (g_reg.sneg == g_reg.dneg[i])
            begin
                if (fs > sbf_pkg::FSW'(sbf_pkg::NEG_LIMIT))
                begin
                    f[i] = sbf_pkg::NEG_LIMIT;
                    sat  = 1'b1;
                end
                else
                begin
                    f[i] = ~fs[sbf_pkg::XW-1:0] + sbf_pkg::XW'(1);
                end
            end
            else
            begin
                if (fs > sbf_pkg::FSW'(sbf_pkg::POS_LIMIT))
                begin
                    f[i] = sbf_pkg::POS_LIMIT;
                    sat  = 1'b1;
                end
                else
                begin
                    f[i] = fs[sbf_pkg::XW-1:0];
                end
            end
        end
        if (g_reg.kill)
        begin
            out_next = '0;
        end
        else
        begin
            out_next.force_x   = f[0];
            out_next.force_y   = f[1];
            out_next.force_z   = f[2];
            out_next.applied   = 1'b1;
            out_next.saturated = sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else if (en)
        begin
            out_valid_reg <= g_reg.vld;
            out_reg       <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_sat_applied: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.saturated |-> out_reg.applied)
        else $error("saturated result without force");

    a_slack_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_reg.applied |->
            out_reg.force_x == '0 && out_reg.force_y == '0 && out_reg.force_z == '0)
        else $error("force on slack or zero separation");

    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        d_reg.vld && !d_reg.kill |-> d_reg.len != '0)
        else $error("force path with zero length");

    a_tail_moves: assert property (@(posedge clk) disable iff (!rst_n)
        g_reg.vld && en |=> out_valid_reg)
        else $error("item lost at output stage");

endmodule
